FILE: rtl/mxu_pkg.sv
`timescale 1ns / 1ps

package mxu_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 4;
	localparam int ELEMS  = 16;
	// four truncated products of at most 64 bits each, summed exactly
	localparam int ACC_W  = 2 * DATA_W + 2;

	// command codes
	localparam logic [2:0] CMD_LOAD_CUR = 3'd0;
	localparam logic [2:0] CMD_LOAD_OP  = 3'd1;
	localparam logic [2:0] CMD_MUL      = 3'd2;
	localparam logic [2:0] CMD_ADD      = 3'd3;
	localparam logic [2:0] CMD_SUB      = 3'd4;
	localparam logic [2:0] CMD_TRANS    = 3'd5;
	localparam logic [2:0] CMD_SCALE    = 3'd6;
	localparam logic [2:0] CMD_READ     = 3'd7;

	localparam logic [IDX_W-1:0] LAST_ELEM = IDX_W'(ELEMS - 1);

	// control word that travels with each read through the datapath
	typedef struct packed {
		logic             vld;
		logic [2:0]       op;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] elem;
	} ctl_t;

	// finished element going back to the current matrix
	typedef struct packed {
		logic                     en;
		logic [IDX_W-1:0]         elem;
		logic signed [DATA_W-1:0] data;
	} wr_t;

	// one emitted item
	typedef struct packed {
		logic [IDX_W-1:0]         index;
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} out_t;

	// clamp the wide accumulator to the signed 32-bit range
	function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic fits;
		fits = (v[ACC_W-1:DATA_W-1] == '0) || (v[ACC_W-1:DATA_W-1] == '1);
		if (fits) begin
			return v[DATA_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

FILE: rtl/mxu_mem.sv
`timescale 1ns / 1ps

module mxu_mem import mxu_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// current matrix, two banks of sixteen, bank select in the top address bit
	input  logic                     cur_we,
	input  logic [IDX_W:0]           cur_waddr,
	input  logic signed [DATA_W-1:0] cur_wdata,
	input  logic                     vld_set,
	input  logic                     vld_all,
	input  logic [IDX_W:0]           cur_raddr,
	output logic signed [DATA_W-1:0] cur_rdata,
	// operand matrix
	input  logic                     op_we,
	input  logic [IDX_W-1:0]         op_waddr,
	input  logic signed [DATA_W-1:0] op_wdata,
	input  logic [IDX_W-1:0]         op_raddr,
	output logic signed [DATA_W-1:0] op_rdata
);

	localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

	logic signed [DATA_W-1:0] cur_ram [2*ELEMS];
	logic signed [DATA_W-1:0] op_ram [ELEMS];
	logic signed [DATA_W-1:0] cur_rd_q;
	logic [ELEMS-1:0]         vld_q;
	logic                     vld_rd_q;
	logic [IDX_W-1:0]         idx_rd_q;
	logic signed [DATA_W-1:0] ident;

	// current matrix storage
	always_ff @(posedge clk) begin
		if (cur_we) begin
			cur_ram[cur_waddr] <= cur_wdata;
		end
		cur_rd_q <= cur_ram[cur_raddr];
		idx_rd_q <= cur_raddr[IDX_W-1:0];
	end

	// operand matrix storage
	always_ff @(posedge clk) begin
		if (op_we) begin
			op_ram[op_waddr] <= op_wdata;
		end
		op_rdata <= op_ram[op_raddr];
	end

	// per-element written flags, unwritten elements read as identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (vld_all) begin
				vld_q <= '1;
			end else if (vld_set) begin
				vld_q[cur_waddr[IDX_W-1:0]] <= 1'b1;
			end
			vld_rd_q <= vld_q[cur_raddr[IDX_W-1:0]];
		end
	end

	// identity element for the registered read position
	assign ident     = (idx_rd_q[3:2] == idx_rd_q[1:0]) ? ONE : '0;
	assign cur_rdata = vld_rd_q ? cur_rd_q : ident;

endmodule

FILE: rtl/mxu_dp.sv
`timescale 1ns / 1ps

module mxu_dp import mxu_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_t                     ctl_s1,
	input  logic signed [DATA_W-1:0] cur_rdata,
	input  logic signed [DATA_W-1:0] op_rdata,
	input  logic signed [DATA_W-1:0] scalar,
	output wr_t                      wr
);

	logic signed [DATA_W-1:0]   b_sel;
	logic signed [2*DATA_W-1:0] prod;
	logic signed [2*DATA_W-1:0] prod_sh;
	logic signed [ACC_W-1:0]    term;
	logic signed [ACC_W-1:0]    term_s2;
	logic signed [ACC_W-1:0]    acc_s3;
	ctl_t                       ctl_s2;
	ctl_t                       ctl_s3;

	// second factor is the operand element for multiply, the scalar for scale
	assign b_sel   = (ctl_s1.op == CMD_MUL) ? op_rdata : scalar;
	assign prod    = cur_rdata * b_sel;
	assign prod_sh = prod >>> FRAC_BITS;

	// per-element term: truncated product, sum, difference or plain copy
	always_comb begin
		case (ctl_s1.op)
			CMD_MUL, CMD_SCALE: term = {{(ACC_W-2*DATA_W){prod_sh[2*DATA_W-1]}}, prod_sh};
			CMD_ADD:            term = ACC_W'(cur_rdata) + ACC_W'(op_rdata);
			CMD_SUB:            term = ACC_W'(cur_rdata) - ACC_W'(op_rdata);
			default:            term = ACC_W'(cur_rdata);
		endcase
	end

	// stage 2: term register
	always_ff @(posedge clk) begin
		term_s2 <= term;
	end

	// stage 3: accumulate the dot product
	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			acc_s3 <= ctl_s2.first ? term_s2 : acc_s3 + term_s2;
		end
	end

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// saturate and hand back for write into the spare bank
	assign wr.en   = ctl_s3.vld && ctl_s3.last;
	assign wr.elem = ctl_s3.elem;
	assign wr.data = sat_acc(acc_s3);

endmodule

FILE: rtl/mxu_ofifo.sv
`timescale 1ns / 1ps

module mxu_ofifo import mxu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  out_t       push_data,
	output logic [1:0] count,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data
);

	out_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rd_ptr_q];
	assign count     = cnt_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/matrix4_multiply_add_unit_top.sv
`timescale 1ns / 1ps
// loads are accepted back to back while idle; no item is emitted for them
// multiply: four reads per element on the current/operand memory ports, then the s1/s2/s3 pipeline, then emit
// add, subtract, transpose, scale: one read per element, then the s1/s2/s3 pipeline, then emit
// read and emit: 16 items, each read issued only while the output FIFO has room; next item taken after last read
// reset: current matrix reads as identity until written, operand matrix undefined until loaded

module matrix4_multiply_add_unit_top import mxu_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               cmd,
	input  logic [IDX_W-1:0]         elem_index,
	input  logic signed [DATA_W-1:0] elem_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDX_W-1:0]         out_index,
	output logic signed [DATA_W-1:0] out_value,
	output logic                     out_last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CALC  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]               state_q;
	logic [2:0]               op_q;
	logic signed [DATA_W-1:0] scalar_q;
	logic [IDX_W-1:0]         e_q;
	logic [1:0]               k_q;
	logic                     act_q;
	ctl_t                     ctl_s1;
	ctl_t                     ctl_nxt;
	logic                     emit_s1;
	logic [IDX_W-1:0]         emit_idx_s1;

	logic                     in_fire;
	logic                     is_mul;
	logic                     calc_last;
	logic                     can_issue;
	logic                     done;
	logic [1:0]               fifo_cnt;
	logic [IDX_W:0]           cur_raddr;
	logic [IDX_W-1:0]         op_raddr;
	logic                     cur_we;
	logic [IDX_W:0]           cur_waddr;
	logic signed [DATA_W-1:0] cur_wdata;
	logic                     vld_set;
	logic signed [DATA_W-1:0] cur_rdata;
	logic signed [DATA_W-1:0] op_rdata;
	wr_t                      wr;
	out_t                     push_data;
	out_t                     out_data;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign is_mul    = (op_q == CMD_MUL);
	assign calc_last = (e_q == LAST_ELEM) && (!is_mul || k_q == 2'd3);
	assign can_issue = (state_q == ST_EMIT) && (({1'b0, fifo_cnt} + {2'b0, emit_s1}) < 3'd2);
	assign done      = (state_q == ST_DRAIN) && wr.en && (wr.elem == LAST_ELEM);

	// read addresses: dot-product walk, transposed walk or straight walk
	always_comb begin
		cur_raddr = {act_q, e_q};
		op_raddr  = e_q;
		if (state_q == ST_CALC) begin
			if (is_mul) begin
				cur_raddr = {act_q, k_q, e_q[1:0]};
				op_raddr  = {e_q[3:2], k_q};
			end else if (op_q == CMD_TRANS) begin
				cur_raddr = {act_q, e_q[1:0], e_q[3:2]};
			end
		end
	end

	// write port: element loads into the live bank, results into the spare bank
	always_comb begin
		vld_set = in_fire && (cmd == CMD_LOAD_CUR);
		if (vld_set) begin
			cur_we    = 1'b1;
			cur_waddr = {act_q, elem_index};
			cur_wdata = elem_value;
		end else begin
			cur_we    = wr.en;
			cur_waddr = {~act_q, wr.elem};
			cur_wdata = wr.data;
		end
	end

	// control word for the item read this cycle
	always_comb begin
		ctl_nxt.vld   = (state_q == ST_CALC);
		ctl_nxt.op    = op_q;
		ctl_nxt.first = !is_mul || (k_q == 2'd0);
		ctl_nxt.last  = !is_mul || (k_q == 2'd3);
		ctl_nxt.elem  = e_q;
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= CMD_READ;
			e_q         <= '0;
			k_q         <= '0;
			act_q       <= 1'b0;
			ctl_s1      <= '0;
			emit_s1     <= 1'b0;
			emit_idx_s1 <= '0;
		end else begin
			ctl_s1      <= ctl_nxt;
			emit_s1     <= can_issue;
			emit_idx_s1 <= e_q;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q <= cmd;
						e_q  <= '0;
						k_q  <= '0;
						case (cmd)
							CMD_LOAD_CUR, CMD_LOAD_OP: state_q <= ST_IDLE;
							CMD_READ:                  state_q <= ST_EMIT;
							default:                   state_q <= ST_CALC;
						endcase
					end
				end
				ST_CALC: begin
					if (calc_last) begin
						state_q <= ST_DRAIN;
					end
					if (!is_mul || k_q == 2'd3) begin
						k_q <= '0;
						e_q <= e_q + 4'd1;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					if (done) begin
						act_q   <= ~act_q;
						e_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (can_issue) begin
						e_q <= e_q + 4'd1;
						if (e_q == LAST_ELEM) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// scale factor captured with the command
	always_ff @(posedge clk) begin
		if (in_fire) begin
			scalar_q <= elem_value;
		end
	end

	mxu_mem #(
		.FRAC_BITS(FRAC_BITS)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.cur_we    (cur_we),
		.cur_waddr (cur_waddr),
		.cur_wdata (cur_wdata),
		.vld_set   (vld_set),
		.vld_all   (done),
		.cur_raddr (cur_raddr),
		.cur_rdata (cur_rdata),
		.op_we     (in_fire && (cmd == CMD_LOAD_OP)),
		.op_waddr  (elem_index),
		.op_wdata  (elem_value),
		.op_raddr  (op_raddr),
		.op_rdata  (op_rdata)
	);

	mxu_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.cur_rdata (cur_rdata),
		.op_rdata  (op_rdata),
		.scalar    (scalar_q),
		.wr        (wr)
	);

	// emitted item from the registered memory read
	assign push_data.index = emit_idx_s1;
	assign push_data.value = cur_rdata;
	assign push_data.last  = (emit_idx_s1 == LAST_ELEM);

	mxu_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s1),
		.push_data (push_data),
		.count     (fifo_cnt),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign out_index = out_data.index;
	assign out_value = out_data.value;
	assign out_last  = out_data.last;

endmodule

FILE: test/matrix4_multiply_add_unit_top_tb.sv
`timescale 1ns / 1ps

module matrix4_multiply_add_unit_top_tb;
	import mxu_pkg::*;

	localparam int FRAC = 16;
	localparam logic signed [DATA_W-1:0] ONE_Q   = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] MAX_Q   = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] MIN_Q   = 32'sh8000_0000;
	localparam int RANDOM_PER_PHASE = 115;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DIRECTED_ROWS    = 25;

	typedef enum int {PH_SND_LIGHT, PH_RCV_LIGHT, PH_STEADY} idle_phase_t;

	// one stimulus row; typed rows carry the expected diagonal and off-diagonal values
	typedef struct packed {
		logic [2:0]               cmd;
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] val;
		logic                     typed;
		logic signed [DATA_W-1:0] diag;
		logic signed [DATA_W-1:0] off_diag;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [2:0]               cmd = CMD_READ;
	logic [IDX_W-1:0]         elem_index = '0;
	logic signed [DATA_W-1:0] elem_value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [IDX_W-1:0]         out_index;
	logic signed [DATA_W-1:0] out_value;
	logic                     out_last;

	// shadow copies of the two matrices
	logic signed [DATA_W-1:0] cur_m [ELEMS];
	logic signed [DATA_W-1:0] op_m [ELEMS];
	out_t expected_elems[$];

	idle_phase_t phase = PH_SND_LIGHT;
	int snd_idle_pct = 11;
	int rcv_idle_pct = 62;
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int cmd_count [8];
	int stall_left = 0;
	bit long_hold_done = 1'b0;

	// directed rows: reset state, scaling into both saturation limits, full operand load, ops
	stim_row_t dir_rows [0:DIRECTED_ROWS-1] = '{
		'{CMD_READ,     4'hF, 32'hDEAD_BEEF, 1'b1, ONE_Q, 32'h0},
		'{CMD_TRANS,    4'hA, 32'h5555_AAAA, 1'b1, ONE_Q, 32'h0},
		'{CMD_SCALE,    4'h3, MAX_Q,         1'b1, MAX_Q, 32'h0},
		'{CMD_SCALE,    4'h0, MAX_Q,         1'b1, MAX_Q, 32'h0},
		'{CMD_SCALE,    4'h7, MIN_Q,         1'b1, MIN_Q, 32'h0},
		'{CMD_LOAD_CUR, 4'h5, MAX_Q,         1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'h0, MIN_Q,         1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'h1, MAX_Q,         1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'h2, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'h3, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'h4, ONE_Q,         1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'h5, MAX_Q,         1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'h6, 32'h0000_8000, 1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'h7, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'h8, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'h9, 32'h0002_0000, 1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'hA, MIN_Q,         1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'hB, 32'h1234_5678, 1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'hC, 32'hFFFF_FFFE, 1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'hD, 32'h0000_C000, 1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'hE, 32'hEDCB_A988, 1'b0, 32'h0, 32'h0},
		'{CMD_LOAD_OP,  4'hF, ONE_Q,         1'b0, 32'h0, 32'h0},
		'{CMD_ADD,      4'hA, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
		'{CMD_SUB,      4'h6, 32'h8000_0001, 1'b0, 32'h0, 32'h0},
		'{CMD_MUL,      4'h9, 32'h7FFF_0000, 1'b0, 32'h0, 32'h0}
	};

	matrix4_multiply_add_unit_top #(
		.FRAC_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.elem_index(elem_index),
		.elem_value(elem_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_index(out_index),
		.out_value(out_value),
		.out_last(out_last)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// fixed-point product, floor of the shifted 64-bit product
	function automatic longint q_mul(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		return (longint'(a) * longint'(b)) >>> FRAC;
	endfunction

	function automatic logic signed [DATA_W-1:0] clamp_q(input longint v);
		if (v > longint'(MAX_Q)) begin
			return MAX_Q;
		end else if (v < longint'(MIN_Q)) begin
			return MIN_Q;
		end
		return v[DATA_W-1:0];
	endfunction

	// update the shadow matrices for one command; returns 1 when the matrix is emitted
	function automatic bit apply_command(input logic [2:0] c, input logic [IDX_W-1:0] ix,
			input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] prev [ELEMS];
		longint acc;
		prev = cur_m;
		case (c)
			CMD_LOAD_CUR: begin
				cur_m[ix] = v;
				return 1'b0;
			end
			CMD_LOAD_OP: begin
				op_m[ix] = v;
				return 1'b0;
			end
			CMD_MUL: begin
				for (int col = 0; col < 4; col++) begin
					for (int r = 0; r < 4; r++) begin
						acc = 0;
						for (int k = 0; k < 4; k++) begin
							acc += q_mul(prev[k*4+r], op_m[col*4+k]);
						end
						cur_m[col*4+r] = clamp_q(acc);
					end
				end
			end
			CMD_ADD: begin
				for (int i = 0; i < ELEMS; i++) begin
					cur_m[i] = clamp_q(longint'(prev[i]) + longint'(op_m[i]));
				end
			end
			CMD_SUB: begin
				for (int i = 0; i < ELEMS; i++) begin
					cur_m[i] = clamp_q(longint'(prev[i]) - longint'(op_m[i]));
				end
			end
			CMD_TRANS: begin
				for (int col = 0; col < 4; col++) begin
					for (int r = 0; r < 4; r++) begin
						cur_m[col*4+r] = prev[r*4+col];
					end
				end
			end
			CMD_SCALE: begin
				for (int i = 0; i < ELEMS; i++) begin
					cur_m[i] = clamp_q(q_mul(prev[i], v));
				end
			end
			default: begin
			end
		endcase
		return 1'b1;
	endfunction

	// queue the 16 elements of the current matrix, or the typed values for a typed row
	function automatic void queue_matrix(input stim_row_t row);
		out_t e;
		for (int i = 0; i < ELEMS; i++) begin
			e.index = IDX_W'(i);
			e.last  = (i == ELEMS - 1);
			if (row.typed) begin
				e.value = (i % 5 == 0) ? row.diag : row.off_diag;
			end else begin
				e.value = cur_m[i];
			end
			expected_elems.push_back(e);
		end
	endfunction

	// mostly small Q16.16 values, some full-range words and some extremes
	function automatic logic signed [DATA_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			return $urandom;
		end else if (sel == 1) begin
			case ($urandom_range(0, 4))
				0: return MAX_Q;
				1: return MIN_Q;
				2: return 32'hFFFF_FFFF;
				3: return ONE_Q;
				default: return 32'h0;
			endcase
		end
		return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < 40) begin
			$display("error at %0t: %s", $time, msg);
		end
		mismatches++;
	endtask

	// offer one item, with a random gap first, and hold it until accepted
	task automatic send_item(input stim_row_t row);
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < snd_idle_pct) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= row.cmd;
		elem_index <= row.idx;
		elem_value <= row.val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		cmd_count[row.cmd]++;
		if (apply_command(row.cmd, row.idx, row.val)) begin
			queue_matrix(row);
		end
	endtask

	task automatic check_result();
		out_t want;
		if (expected_elems.size() == 0) begin
			flag_mismatch($sformatf("unexpected item index %0d value %h", out_index, out_value));
			return;
		end
		want = expected_elems.pop_front();
		results_seen++;
		if (out_index !== want.index) begin
			flag_mismatch($sformatf("index %0d, want %0d", out_index, want.index));
		end
		if (out_value !== want.value) begin
			flag_mismatch($sformatf("value %h at index %0d, want %h", out_value, want.index,
				want.value));
		end
		if (out_last !== want.last) begin
			flag_mismatch($sformatf("last %b at index %0d, want %b", out_last, want.index,
				want.last));
		end
	endtask

	// receiver: random back-pressure, plus one long hold once the steady phase starts
	always @(posedge clk) begin
		if (phase == PH_STEADY && !long_hold_done) begin
			long_hold_done = 1'b1;
			stall_left = LONG_HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			check_result();
		end
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("timeout: results stopped arriving");
		$display("Mismatches found");
		$finish;
	end

	// stimulus
	initial begin
		stim_row_t row;
		for (int i = 0; i < ELEMS; i++) begin
			cur_m[i] = (i % 5 == 0) ? ONE_Q : 32'h0;
			op_m[i]  = 32'h0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_item(dir_rows[i]);
		end

		// random part in three idle phases
		for (int p = 0; p < 3; p++) begin
			phase = idle_phase_t'(p);
			case (phase)
				PH_SND_LIGHT: begin
					snd_idle_pct = 11;
					rcv_idle_pct = 62;
				end
				PH_RCV_LIGHT: begin
					snd_idle_pct = 62;
					rcv_idle_pct = 11;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				row = '0;
				if ($urandom_range(0, 9) < 6) begin
					row.cmd = $urandom_range(0, 1) ? CMD_LOAD_OP : CMD_LOAD_CUR;
				end else begin
					row.cmd = 3'($urandom_range(2, 7));
				end
				row.idx = 4'($urandom_range(0, 15));
				row.val = pick_value();
				send_item(row);
			end
		end
		in_valid <= 1'b0;

		// drain, then watch for stray items
		while (expected_elems.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("sent %0d items (%0d element loads), checked %0d result elements",
			items_sent, cmd_count[CMD_LOAD_CUR] + cmd_count[CMD_LOAD_OP], results_seen);
		$display("multiply %0d, add %0d, subtract %0d, transpose %0d, scale %0d, read %0d",
			cmd_count[CMD_MUL], cmd_count[CMD_ADD], cmd_count[CMD_SUB],
			cmd_count[CMD_TRANS], cmd_count[CMD_SCALE], cmd_count[CMD_READ]);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
